>>> design/avlc_pkg.sv
package avlc_pkg;

    localparam int MaxFrameBytes = 4095;
    localparam int MinFrameBytes = 11;
    localparam int PlenMax       = 4095;

    localparam logic [15:0] CrcPreset  = 16'hFFFF;
    localparam logic [15:0] ResidueOk  = 16'hF0B8;
    localparam logic [15:0] CrcPoly    = 16'h8408;

    localparam logic [1:0] StatusOk    = 2'd0;
    localparam logic [1:0] StatusShort = 2'd1;
    localparam logic [1:0] StatusFcs   = 2'd2;

    localparam logic [1:0] FrameI = 2'd0;
    localparam logic [1:0] FrameS = 2'd1;
    localparam logic [1:0] FrameU = 2'd2;

    localparam logic [1:0] PayAcars   = 2'd0;
    localparam logic [1:0] PayX25     = 2'd1;
    localparam logic [1:0] PayXid     = 2'd2;
    localparam logic [1:0] PayUnknown = 2'd3;

    localparam logic [1:0] SendAircraft = 2'd0;
    localparam logic [1:0] SendGround   = 2'd1;
    localparam logic [1:0] SendOther    = 2'd2;

    localparam logic [2:0] KindAircraft = 3'd1;
    localparam logic [2:0] KindGroundA  = 3'd4;
    localparam logic [2:0] KindGroundB  = 3'd5;

    localparam logic [5:0] XidMask  = 6'h3B;
    localparam logic [5:0] XidMatch = 6'h2B;
    localparam logic [23:0] AcarsPrefix = 24'h01FFFF;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_word;

    typedef struct packed {
        logic [1:0]  result_status;
        logic [23:0] dest_address;
        logic [2:0]  dest_kind;
        logic        dest_flag;
        logic [23:0] source_address;
        logic [2:0]  source_kind;
        logic        source_flag;
        logic [1:0]  frame_class;
        logic [7:0]  control_value;
        logic [1:0]  payload_class;
        logic [1:0]  sender_class;
        logic [11:0] payload_length;
    } t_out_word;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
        end
        return c;
    endfunction

    function automatic logic [27:0] rev28(input logic [27:0] v);
        logic [27:0] r;
        for (int i = 0; i < 28; i++) begin
            r[27 - i] = v[i];
        end
        return r;
    endfunction

endpackage

>>> design/avlc_frame_header_checker.sv
// Channel  Direction  Handshake                          Payload
// input    in         i_in_valid / o_in_ready            i_in_data  (t_in_word)
// output   out        o_out_valid / i_out_ready          o_out_data (t_out_word)
//
// One word is accepted per cycle unless a stalled output blocks the input; each byte is held
// in the input register and its CRC update and field capture are done on the way out of it.
// A final byte passes through the input register and yields a result held in the output register.
// A stalled output holds a final byte in the input register, which then blocks the input.
// Reset is synchronous and active low; it presets the CRC and clears all frame state.
module avlc_frame_header_checker #(
    parameter int MAX_FRAME_BYTES = avlc_pkg::MaxFrameBytes,
    parameter int MIN_FRAME_BYTES = avlc_pkg::MinFrameBytes
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  avlc_pkg::t_in_word  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output avlc_pkg::t_out_word o_out_data
);

    localparam int CW = $clog2(MAX_FRAME_BYTES + 1);
    localparam int PW = (CW > 12) ? CW : 12;

    logic                r_in_valid;
    avlc_pkg::t_in_word  r_in;
    logic                r_out_valid;
    avlc_pkg::t_out_word r_out;

    logic [15:0]   r_crc, n_crc;
    logic [CW-1:0] r_count, n_count;
    logic [27:0]   r_dest, n_dest;
    logic [27:0]   r_src, n_src;
    logic [7:0]    r_ctl, n_ctl;
    logic [23:0]   r_prefix, n_prefix;

    logic                w_out_free;
    logic                w_take;
    logic [PW-1:0]       w_plen_full;
    logic [11:0]         w_plen;
    logic [27:0]         w_d;
    logic [27:0]         w_s;
    avlc_pkg::t_out_word n_out;

    assign w_out_free  = !r_out_valid || i_out_ready;
    assign w_take      = r_in_valid && (!r_in.last_byte || w_out_free);
    assign o_in_ready  = !r_in_valid || w_take;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_comb begin
        n_crc    = avlc_pkg::crc_byte(r_crc, r_in.data_byte);
        n_dest   = r_dest;
        n_src    = r_src;
        n_ctl    = r_ctl;
        n_prefix = r_prefix;
        if (r_count < CW'(4)) begin
            case (r_count[1:0])
                2'd0: n_dest[6:0]   = r_dest[6:0]   | r_in.data_byte[7:1];
                2'd1: n_dest[13:7]  = r_dest[13:7]  | r_in.data_byte[7:1];
                2'd2: n_dest[20:14] = r_dest[20:14] | r_in.data_byte[7:1];
                default: n_dest[27:21] = r_dest[27:21] | r_in.data_byte[7:1];
            endcase
        end else if (r_count < CW'(8)) begin
            case (r_count[1:0])
                2'd0: n_src[6:0]   = r_src[6:0]   | r_in.data_byte[7:1];
                2'd1: n_src[13:7]  = r_src[13:7]  | r_in.data_byte[7:1];
                2'd2: n_src[20:14] = r_src[20:14] | r_in.data_byte[7:1];
                default: n_src[27:21] = r_src[27:21] | r_in.data_byte[7:1];
            endcase
        end else if (r_count == CW'(8)) begin
            n_ctl = r_in.data_byte;
        end else if (r_count == CW'(9)) begin
            n_prefix[7:0] = r_prefix[7:0] | r_in.data_byte;
        end else if (r_count == CW'(10)) begin
            n_prefix[15:8] = r_prefix[15:8] | r_in.data_byte;
        end else if (r_count == CW'(11)) begin
            n_prefix[23:16] = r_prefix[23:16] | r_in.data_byte;
        end
        n_count = (r_count < CW'(MAX_FRAME_BYTES)) ? r_count + CW'(1) : r_count;

        w_plen_full = PW'(n_count) - PW'(MIN_FRAME_BYTES);
        w_plen = (w_plen_full > PW'(avlc_pkg::PlenMax)) ? 12'hFFF : w_plen_full[11:0];
        w_d = avlc_pkg::rev28(n_dest);
        w_s = avlc_pkg::rev28(n_src);

        n_out = '0;
        if (n_count < CW'(MIN_FRAME_BYTES)) begin
            n_out.result_status = avlc_pkg::StatusShort;
        end else if (n_crc != avlc_pkg::ResidueOk) begin
            n_out.result_status = avlc_pkg::StatusFcs;
        end else begin
            n_out.result_status  = avlc_pkg::StatusOk;
            n_out.dest_address   = w_d[24:1];
            n_out.dest_kind      = w_d[27:25];
            n_out.dest_flag      = w_d[0];
            n_out.source_address = w_s[24:1];
            n_out.source_kind    = w_s[27:25];
            n_out.source_flag    = w_s[0];
            n_out.control_value  = n_ctl;
            n_out.payload_length = w_plen;
            if (!n_ctl[0]) begin
                n_out.frame_class = avlc_pkg::FrameI;
                n_out.payload_class = (w_plen > 12'd3 && n_prefix == avlc_pkg::AcarsPrefix)
                                      ? avlc_pkg::PayAcars : avlc_pkg::PayX25;
            end else if (!n_ctl[1]) begin
                n_out.frame_class   = avlc_pkg::FrameS;
                n_out.payload_class = avlc_pkg::PayUnknown;
            end else begin
                n_out.frame_class = avlc_pkg::FrameU;
                n_out.payload_class = ((n_ctl[7:2] & avlc_pkg::XidMask) == avlc_pkg::XidMatch)
                                      ? avlc_pkg::PayXid : avlc_pkg::PayUnknown;
            end
            if (w_s[27:25] == avlc_pkg::KindAircraft) begin
                n_out.sender_class = avlc_pkg::SendAircraft;
            end else if (w_s[27:25] == avlc_pkg::KindGroundA ||
                         w_s[27:25] == avlc_pkg::KindGroundB) begin
                n_out.sender_class = avlc_pkg::SendGround;
            end else begin
                n_out.sender_class = avlc_pkg::SendOther;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_crc       <= avlc_pkg::CrcPreset;
            r_count     <= '0;
            r_dest      <= '0;
            r_src       <= '0;
            r_ctl       <= '0;
            r_prefix    <= '0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (w_take && r_in.last_byte) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (w_take) begin
                if (r_in.last_byte) begin
                    r_crc    <= avlc_pkg::CrcPreset;
                    r_count  <= '0;
                    r_dest   <= '0;
                    r_src    <= '0;
                    r_ctl    <= '0;
                    r_prefix <= '0;
                end else begin
                    r_crc    <= n_crc;
                    r_count  <= n_count;
                    r_dest   <= n_dest;
                    r_src    <= n_src;
                    r_ctl    <= n_ctl;
                    r_prefix <= n_prefix;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready) begin
            r_in <= i_in_data;
        end
        if (w_take && r_in.last_byte) begin
            r_out <= n_out;
        end
    end

endmodule

>>> sim/tb_avlc_frame_header_checker.sv
`timescale 1ns / 100ps

module tb_avlc_frame_header_checker;

    typedef struct {
        avlc_pkg::t_in_word  word;
        bit                  pinned;
        avlc_pkg::t_out_word pinned_report;
    } t_rx_byte;

    typedef enum logic [1:0] {RowByte, RowShortEnd, RowSealGood, RowSealBad} t_row_kind;
    typedef enum logic [1:0] {PickI, PickS, PickXid, PickU} t_ctl_pick;

    localparam int DirRows = 20;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_in_valid = 1'b0;
    logic                o_in_ready;
    avlc_pkg::t_in_word  i_in_data = '0;
    logic                o_out_valid;
    logic                i_out_ready = 1'b0;
    avlc_pkg::t_out_word o_out_data;

    t_rx_byte            byte_backlog[$];
    avlc_pkg::t_out_word pending_reports[$];
    logic [7:0]          frame_body[$];
    logic [9:0]          directed_table [DirRows];

    // Running state of the header tracker.
    logic [15:0] fcs_acc;
    int          seen_count;
    logic [27:0] dest_bits;
    logic [27:0] source_bits;
    logic [7:0]  control_seen;
    logic [23:0] prefix_seen;

    t_rx_byte            on_wire;
    bit                  closes;
    avlc_pkg::t_out_word report;
    int                  send_gap = 0;
    int                  take_gap = 0;
    bit                  held_back = 1'b0;
    bit                  quiet = 1'b0;
    int                  reports_seen = 0;
    int                  failures = 0;

    avlc_frame_header_checker u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    always #5 i_clk = ~i_clk;

    function automatic logic [15:0] fold_crc(input logic [15:0] acc, input logic [7:0] b);
        logic [15:0] r;
        r = acc;
        for (int k = 0; k < 8; k++) begin
            if (r[0] ^ b[k]) begin
                r = (r >> 1) ^ avlc_pkg::CrcPoly;
            end else begin
                r = r >> 1;
            end
        end
        return r;
    endfunction

    task automatic clear_tracker();
        fcs_acc      = avlc_pkg::CrcPreset;
        seen_count   = 0;
        dest_bits    = '0;
        source_bits  = '0;
        control_seen = '0;
        prefix_seen  = '0;
    endtask

    task automatic track_byte(input avlc_pkg::t_in_word w, output bit done,
                              output avlc_pkg::t_out_word rep);
        logic [7:0]  b;
        logic [27:0] d_rev;
        logic [27:0] s_rev;
        int          idx;
        int          plen;
        b = w.data_byte;
        idx = seen_count;
        rep = '0;
        fcs_acc = fold_crc(fcs_acc, b);
        if (idx < 4) begin
            dest_bits[7 * idx +: 7] = b[7:1];
        end else if (idx < 8) begin
            source_bits[7 * (idx - 4) +: 7] = b[7:1];
        end else if (idx == 8) begin
            control_seen = b;
        end else if (idx < 12) begin
            prefix_seen[8 * (idx - 9) +: 8] = b;
        end
        if (seen_count < avlc_pkg::MaxFrameBytes) begin
            seen_count++;
        end
        done = w.last_byte;
        if (done) begin
            if (seen_count < avlc_pkg::MinFrameBytes) begin
                rep.result_status = avlc_pkg::StatusShort;
            end else if (fcs_acc != avlc_pkg::ResidueOk) begin
                rep.result_status = avlc_pkg::StatusFcs;
            end else begin
                for (int i = 0; i < 28; i++) begin
                    d_rev[27 - i] = dest_bits[i];
                    s_rev[27 - i] = source_bits[i];
                end
                plen = seen_count - avlc_pkg::MinFrameBytes;
                rep.result_status  = avlc_pkg::StatusOk;
                rep.dest_flag      = d_rev[0];
                rep.dest_address   = d_rev[24:1];
                rep.dest_kind      = d_rev[27:25];
                rep.source_flag    = s_rev[0];
                rep.source_address = s_rev[24:1];
                rep.source_kind    = s_rev[27:25];
                rep.control_value  = control_seen;
                rep.payload_length = plen[11:0];
                if (!control_seen[0]) begin
                    rep.frame_class   = avlc_pkg::FrameI;
                    rep.payload_class = (plen > 3 && prefix_seen == avlc_pkg::AcarsPrefix) ?
                                        avlc_pkg::PayAcars : avlc_pkg::PayX25;
                end else if (control_seen[1:0] == 2'b01) begin
                    rep.frame_class   = avlc_pkg::FrameS;
                    rep.payload_class = avlc_pkg::PayUnknown;
                end else begin
                    rep.frame_class   = avlc_pkg::FrameU;
                    rep.payload_class =
                        ((control_seen[7:2] & avlc_pkg::XidMask) == avlc_pkg::XidMatch) ?
                        avlc_pkg::PayXid : avlc_pkg::PayUnknown;
                end
                if (s_rev[27:25] == avlc_pkg::KindAircraft) begin
                    rep.sender_class = avlc_pkg::SendAircraft;
                end else if (s_rev[27:25] == avlc_pkg::KindGroundA ||
                             s_rev[27:25] == avlc_pkg::KindGroundB) begin
                    rep.sender_class = avlc_pkg::SendGround;
                end else begin
                    rep.sender_class = avlc_pkg::SendOther;
                end
            end
            clear_tracker();
        end
    endtask

    task automatic offer(input logic [7:0] b, input bit last, input bit pinned,
                         input logic [1:0] pin_status);
        t_rx_byte item;
        item.word.data_byte = b;
        item.word.last_byte = last;
        item.pinned = pinned;
        item.pinned_report = '0;
        item.pinned_report.result_status = pin_status;
        byte_backlog.push_back(item);
    endtask

    // Queues the frame body and then its FCS, low byte first, optionally with one bit flipped.
    task automatic seal_frame(input bit corrupt, input bit pinned);
        logic [15:0] acc;
        logic [15:0] fcs;
        acc = avlc_pkg::CrcPreset;
        for (int k = 0; k < frame_body.size(); k++) begin
            acc = fold_crc(acc, frame_body[k]);
        end
        fcs = ~acc;
        if (corrupt) begin
            fcs = fcs ^ (16'h0001 << $urandom_range(0, 15));
        end
        for (int k = 0; k < frame_body.size(); k++) begin
            offer(frame_body[k], 1'b0, 1'b0, avlc_pkg::StatusOk);
        end
        offer(fcs[7:0], 1'b0, 1'b0, avlc_pkg::StatusOk);
        offer(fcs[15:8], 1'b1, pinned, avlc_pkg::StatusFcs);
        frame_body.delete();
    endtask

    task automatic build_header(output bit is_i_frame);
        logic [7:0] ctl;
        t_ctl_pick  pick;
        frame_body.delete();
        repeat (8) frame_body.push_back(8'($urandom_range(0, 255)));
        pick = t_ctl_pick'($urandom_range(0, 3));
        case (pick)
            PickI: begin
                ctl = 8'($urandom_range(0, 255)) & 8'hFE;
            end
            PickS: begin
                ctl = {6'($urandom_range(0, 63)), 2'b01};
            end
            PickXid: begin
                ctl = {3'b101, 1'($urandom_range(0, 1)), 4'b1111};
            end
            default: begin
                ctl = {6'($urandom_range(0, 63)), 2'b11};
            end
        endcase
        is_i_frame = (pick == PickI);
        frame_body.push_back(ctl);
    endtask

    task automatic add_payload(input int n, input bit acars);
        for (int k = 0; k < n; k++) begin
            if (acars && k < 3) begin
                frame_body.push_back(avlc_pkg::AcarsPrefix[8 * k +: 8]);
            end else begin
                frame_body.push_back(8'($urandom_range(0, 255)));
            end
        end
    endtask

    task automatic compare_field(input string what, input logic [23:0] want,
                                 input logic [23:0] got);
        if (want !== got) begin
            $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
            failures++;
        end
    endtask

    task automatic compare_report(input avlc_pkg::t_out_word want,
                                  input avlc_pkg::t_out_word got);
        compare_field("result_status", 24'(want.result_status), 24'(got.result_status));
        compare_field("dest_address", want.dest_address, got.dest_address);
        compare_field("dest_kind", 24'(want.dest_kind), 24'(got.dest_kind));
        compare_field("dest_flag", 24'(want.dest_flag), 24'(got.dest_flag));
        compare_field("source_address", want.source_address, got.source_address);
        compare_field("source_kind", 24'(want.source_kind), 24'(got.source_kind));
        compare_field("source_flag", 24'(want.source_flag), 24'(got.source_flag));
        compare_field("frame_class", 24'(want.frame_class), 24'(got.frame_class));
        compare_field("control_value", 24'(want.control_value), 24'(got.control_value));
        compare_field("payload_class", 24'(want.payload_class), 24'(got.payload_class));
        compare_field("sender_class", 24'(want.sender_class), 24'(got.sender_class));
        compare_field("payload_length", 24'(want.payload_length),
                      24'(got.payload_length));
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            quiet <= 1'b0;
            clear_tracker();
        end else begin
            if (i_in_valid && o_in_ready) begin
                track_byte(on_wire.word, closes, report);
                if (closes) begin
                    pending_reports.push_back(on_wire.pinned ? on_wire.pinned_report : report);
                end
            end
            if (!i_in_valid || o_in_ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    i_in_valid <= 1'b0;
                end else if (byte_backlog.size() == 0) begin
                    i_in_valid <= 1'b0;
                end else if (!quiet && $urandom_range(0, 15) == 0) begin
                    send_gap = $urandom_range(0, 17);
                    i_in_valid <= 1'b0;
                end else begin
                    on_wire = byte_backlog.pop_front();
                    i_in_valid <= 1'b1;
                    i_in_data <= on_wire.word;
                end
            end
            quiet <= (byte_backlog.size() < 120);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (pending_reports.size() == 0) begin
                    $display("%0t ns: unexpected result, expected none, actual %h",
                             $time, o_out_data);
                    failures++;
                end else begin
                    compare_report(pending_reports.pop_front(), o_out_data);
                end
                reports_seen++;
            end
            // One long hold-off so that a final word backs up into the input.
            if (take_gap > 0) begin
                take_gap--;
                i_out_ready <= 1'b0;
            end else if (!held_back && reports_seen >= 10) begin
                held_back = 1'b1;
                take_gap = 399;
                i_out_ready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 15) == 0) begin
                take_gap = $urandom_range(0, 17);
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    initial begin
        logic [9:0] row;
        bit         is_i;
        int         pick;
        int         n;
        int         mark;
        int         regular_items;
        int         long_frames;
        int         long_len;

        directed_table = '{
            {RowShortEnd, 8'h00}, {RowShortEnd, 8'hFF},
            {RowByte, 8'hFF}, {RowByte, 8'hFF}, {RowByte, 8'hFF}, {RowByte, 8'hFF},
            {RowByte, 8'h00}, {RowByte, 8'h00}, {RowByte, 8'h00}, {RowByte, 8'h00},
            {RowSealGood, 8'hFF},
            {RowByte, 8'h00}, {RowByte, 8'h00}, {RowByte, 8'h00}, {RowByte, 8'h00},
            {RowByte, 8'hFF}, {RowByte, 8'hFF}, {RowByte, 8'hFF}, {RowByte, 8'hFF},
            {RowSealBad, 8'h00}
        };
        for (int r = 0; r < DirRows; r++) begin
            row = directed_table[r];
            case (t_row_kind'(row[9:8]))
                RowByte: begin
                    frame_body.push_back(row[7:0]);
                end
                RowShortEnd: begin
                    offer(row[7:0], 1'b1, 1'b1, avlc_pkg::StatusShort);
                end
                RowSealGood: begin
                    frame_body.push_back(row[7:0]);
                    seal_frame(1'b0, 1'b0);
                end
                default: begin
                    frame_body.push_back(row[7:0]);
                    seal_frame(1'b1, 1'b1);
                end
            endcase
        end

        regular_items = 0;
        long_frames = 0;
        while (regular_items < 800) begin
            // A few frames long enough to saturate the byte counter.
            if (long_frames < 3 && regular_items >= 200 * (long_frames + 1)) begin
                long_len = (long_frames == 0) ? 4095 : (long_frames == 1) ? 4096 : 4200;
                build_header(is_i);
                add_payload(long_len - 11, 1'b0);
                seal_frame(1'b0, 1'b0);
                long_frames++;
            end
            mark = byte_backlog.size();
            pick = $urandom_range(0, 99);
            if (pick < 80) begin
                build_header(is_i);
                n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4) : $urandom_range(5, 24);
                add_payload(n, is_i && n >= 3 && $urandom_range(0, 1) == 1);
                seal_frame(pick >= 70, 1'b0);
            end else begin
                n = (pick < 92) ? $urandom_range(1, 10) : $urandom_range(11, 30);
                for (int k = 0; k < n; k++) begin
                    offer(8'($urandom_range(0, 255)), k == n - 1, 1'b0, avlc_pkg::StatusOk);
                end
            end
            regular_items += byte_backlog.size() - mark;
        end

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (byte_backlog.size() != 0 || i_in_valid) @(posedge i_clk);
        while (pending_reports.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (failures == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        #15_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule

>>> sim.f
design/avlc_pkg.sv
design/avlc_frame_header_checker.sv
sim/tb_avlc_frame_header_checker.sv
